/* design/sabtb_pkg.sv */
// Shared widths, field positions and operation codes of the branch target buffer.
package sabtb_pkg;

    localparam int ADDR_W     = 32;
    localparam int DIGIT_BITS = 4;

    // Slave-side tdata: branch_addr, taken, correct, branch_target, then zero fill.
    localparam int S_ADDR_LSB    = 0;
    localparam int S_TAKEN_BIT   = S_ADDR_LSB + ADDR_W;
    localparam int S_CORRECT_BIT = S_TAKEN_BIT + 1;
    localparam int S_TARGET_LSB  = S_CORRECT_BIT + 1;
    localparam int S_TDATA_W     = 72;
    localparam int S_TUSER_W     = 1;

    localparam int M_TDATA_W = ADDR_W;
    localparam int M_TUSER_W = 1;

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_UPDATE = 1'b1
    } t_func;

endpackage

/* design/set_assoc_branch_target_buffer.sv */
// Set-associative branch target buffer with true LRU replacement, one RAM row per set.
// A transaction's set row is read into the RAM output register (after the set index
//   remainder unit when NUM_SETS is not a power of two), then its result is registered.
// Throughput: one transaction per cycle with a power-of-two set count while the result is not
//   stalled, set by the one read-modify-write of the set row; otherwise a new transaction is
//   accepted only once the four-bits-per-cycle set index remainder unit has finished.
// Reset: synchronous, active low; afterwards a clearing pass writes every row (address 0,
//   target 0, rank equal to way) while o_s_tready stays low.
module set_assoc_branch_target_buffer #(
    parameter int NUM_SETS    = 512,
    parameter int NUM_WAYS    = 4,
    parameter int INDEX_SHIFT = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Fields from bit 0 up: branch_addr[31:0], taken, correct, branch_target[31:0], zero fill.
    input  logic [sabtb_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Fields from bit 0 up: func (0 lookup, 1 update).
    input  logic [sabtb_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Fields from bit 0 up: predicted_target[31:0].
    output logic [sabtb_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Fields from bit 0 up: hit.
    output logic [sabtb_pkg::M_TUSER_W-1:0] o_m_tuser
);
    localparam int AW      = sabtb_pkg::ADDR_W;
    localparam int IW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RKW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W   = NUM_WAYS * (2 * AW + RKW);
    localparam bit IS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam int SW      = AW - INDEX_SHIFT;
    localparam int DB      = sabtb_pkg::DIGIT_BITS;
    localparam int DIG     = (SW + DB - 1) / DB;
    localparam int DPW     = DIG * DB;
    localparam int DCW     = $clog2(DIG + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LOOK
    } t_state;

    t_state                 r_state;
    logic [IW-1:0]          r_clr;
    logic [IW-1:0]          r_idx;
    sabtb_pkg::t_func       r_func;
    logic [AW-1:0]          r_addr;
    logic                   r_taken;
    logic                   r_correct;
    logic [AW-1:0]          r_target;
    logic [IW-1:0]          r_rem;
    logic [DPW-1:0]         r_dsh;
    logic [DCW-1:0]         r_dcnt;
    logic                   r_fwd_sel;
    logic [ROW_W-1:0]       r_fwd_row;
    logic                   r_out_valid;
    logic [AW-1:0]          r_out_target;
    logic                   r_out_hit;

    // Input transaction fields.
    sabtb_pkg::t_func       in_func;
    logic [AW-1:0]          in_addr;
    logic [AW-1:0]          in_target;
    logic [SW-1:0]          in_shift;
    logic [IW-1:0]          idx_direct;

    logic                   s_fire;
    logic                   out_ok;
    logic                   look_go;
    logic                   div_last;
    logic [IW-1:0]          div_rem;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [ROW_W-1:0]       ram_rdata;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [ROW_W-1:0]       wr_data;

    logic [ROW_W-1:0]       row_cur;
    logic [ROW_W-1:0]       new_row;
    logic [ROW_W-1:0]       clear_row;
    logic [NUM_WAYS-1:0][AW-1:0]  way_addr;
    logic [NUM_WAYS-1:0][AW-1:0]  way_tgt;
    logic [NUM_WAYS-1:0][RKW-1:0] way_rank;
    logic [NUM_WAYS-1:0][AW-1:0]  nw_addr;
    logic [NUM_WAYS-1:0][AW-1:0]  nw_tgt;
    logic [NUM_WAYS-1:0][RKW-1:0] nw_rank;
    logic [NUM_WAYS-1:0][AW-1:0]  cl_addr;
    logic [NUM_WAYS-1:0][AW-1:0]  cl_tgt;
    logic [NUM_WAYS-1:0][RKW-1:0] cl_rank;
    logic                   hit_any;
    logic [RKW-1:0]         hit_way;
    logic [RKW-1:0]         lru_way;
    logic [RKW-1:0]         sel_way;
    logic [RKW-1:0]         sel_rank;

    assign in_func    = sabtb_pkg::t_func'(i_s_tuser[0]);
    assign in_addr    = i_s_tdata[sabtb_pkg::S_ADDR_LSB +: AW];
    assign in_target  = i_s_tdata[sabtb_pkg::S_TARGET_LSB +: AW];
    assign in_shift   = in_addr[AW-1:INDEX_SHIFT];
    // With a power-of-two set count the set index is a plain bit field.
    assign idx_direct = (NUM_SETS == 1) ? '0 : in_shift[IW-1:0];

    // Input is taken in idle, or in lookup while the result register is free or drains this cycle.
    assign out_ok     = !r_out_valid || i_m_tready;
    assign look_go    = (r_state == S_LOOK) && out_ok;
    assign o_s_tready = (r_state == S_IDLE) || look_go;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign div_last   = (r_state == S_DIV) && (r_dcnt == DCW'(DIG - 1));

    // Remainder unit for other set counts: four address bits per cycle, most significant
    // first, each step one compare and subtract on a value below twice the set count.
    always_comb begin
        logic [IW:0] t;
        div_rem = r_rem;
        for (int k = 0; k < DB; k++) begin
            t = {div_rem, r_dsh[DPW-1-k]};
            if (t >= (IW+1)'(NUM_SETS)) begin
                t = t - (IW+1)'(NUM_SETS);
            end
            div_rem = t[IW-1:0];
        end
    end

    assign rd_en   = (s_fire && IS_POW2) || div_last;
    assign rd_addr = div_last ? div_rem : idx_direct;

    // A row just written in the previous cycle is taken from the bypass register.
    assign row_cur  = r_fwd_sel ? r_fwd_row : ram_rdata;
    assign way_addr = row_cur[NUM_WAYS*AW-1:0];
    assign way_tgt  = row_cur[2*NUM_WAYS*AW-1:NUM_WAYS*AW];
    assign way_rank = row_cur[ROW_W-1:2*NUM_WAYS*AW];

    // Lowest matching way, and the way holding the oldest rank. Ranks always form a
    // permutation of the way numbers, so exactly one way carries the oldest rank.
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        lru_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (way_addr[w] == r_addr) begin
                hit_any = 1'b1;
                hit_way = RKW'(w);
            end
            if (way_rank[w] == RKW'(NUM_WAYS - 1)) begin
                lru_way = RKW'(w);
            end
        end
    end

    assign sel_way  = hit_any ? hit_way : lru_way;
    assign sel_rank = way_rank[sel_way];

    // Updated row for a taken branch: selected way becomes most recent, every way that was more recent
    // than it ages by one; a miss fills the oldest way with address and target, an incorrect hit gets the target.
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            nw_addr[w] = way_addr[w];
            nw_tgt[w]  = way_tgt[w];
            if (RKW'(w) == sel_way) begin
                nw_rank[w] = '0;
                if (!hit_any) begin
                    nw_addr[w] = r_addr;
                end
                if (!hit_any || !r_correct) begin
                    nw_tgt[w] = r_target;
                end
            end else if (way_rank[w] < sel_rank) begin
                nw_rank[w] = way_rank[w] + RKW'(1);
            end else begin
                nw_rank[w] = way_rank[w];
            end
        end
    end

    assign new_row = {nw_rank, nw_tgt, nw_addr};

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            cl_addr[w] = '0;
            cl_tgt[w]  = '0;
            cl_rank[w] = RKW'(w);
        end
    end

    assign clear_row = {cl_rank, cl_tgt, cl_addr};

    assign wr_en   = (r_state == S_CLEAR) ||
                     (look_go && (r_func == sabtb_pkg::FUNC_UPDATE) && r_taken);
    assign wr_addr = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign wr_data = (r_state == S_CLEAR) ? clear_row : new_row;

    sabtb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fwd_sel   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (s_fire) begin
                r_func    <= in_func;
                r_addr    <= in_addr;
                r_taken   <= i_s_tdata[sabtb_pkg::S_TAKEN_BIT];
                r_correct <= i_s_tdata[sabtb_pkg::S_CORRECT_BIT];
                r_target  <= in_target;
                r_rem     <= '0;
                r_dsh     <= DPW'(in_shift);
                r_dcnt    <= '0;
                if (IS_POW2) begin
                    r_idx <= idx_direct;
                end
            end

            // The bypass is armed when the row being read is the one written right now.
            if (rd_en) begin
                r_fwd_sel <= !div_last && wr_en && (idx_direct == r_idx);
                r_fwd_row <= new_row;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_state <= IS_POW2 ? S_LOOK : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_rem;
                    r_dsh  <= r_dsh << DB;
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (div_last) begin
                        r_idx   <= div_rem;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (look_go) begin
                        r_out_valid  <= 1'b1;
                        r_out_hit    <= (r_func == sabtb_pkg::FUNC_LOOKUP) && hit_any;
                        r_out_target <= ((r_func == sabtb_pkg::FUNC_LOOKUP) && hit_any) ?
                                        way_tgt[hit_way] : '0;
                        if (s_fire) begin
                            r_state <= IS_POW2 ? S_LOOK : S_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_target;
    assign o_m_tuser  = r_out_hit;

endmodule

/* design/sabtb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sabtb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the row written in the same cycle returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sabtb_chk.sv */
// Port-level checker for the branch target buffer and its bind to the top level.
module sabtb_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            o_s_tready,
    input  logic [sabtb_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [sabtb_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sabtb_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic [sabtb_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // Reset empties the result register.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Reset starts the clearing pass, which refuses input transactions.
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    // A miss or an update result always carries a zero target.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("nonzero target without a hit");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // An input transaction that is held off keeps being offered unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && !o_s_tready) |=>
        (i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser)))
        else $error("stalled input transaction changed");

endmodule

bind set_assoc_branch_target_buffer sabtb_chk u_sabtb_chk (.*);
